// ===== hw/rtl/base64_stream_decoder_macros.svh =====
// Assertion macros for the Base64 stream decoder.
// Included by the top level, which checks its own logic; no other dependencies.
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64D_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define B64D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/b64d_pkg.sv =====
// Shared types, constants and the alphabet decode function of the Base64 decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

    localparam logic [7:0] PAD_CHAR   = 8'h3d;
    localparam logic       KIND_BYTE  = 1'b0;
    localparam logic       KIND_ERROR = 1'b1;

    // Result queue geometry
    localparam int QDEPTH = 8;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);
    localparam int MAX_PUSH = 3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_kind;
        logic       last_of_run;
        logic       message_done;
    } t_result;

    // Up to three results produced by one character
    typedef struct packed {
        logic [1:0]        count;
        t_result [2:0]     res;
    } t_push;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sym;

    // Map a character to its 6-bit symbol; ok is low outside the alphabet.
    function automatic t_sym symbol_of(input logic [7:0] c);
        t_sym s;
        s.ok  = 1'b1;
        s.val = 6'd0;
        if (c[7]) begin
            s.ok = 1'b0;
        end else if (c inside {[8'h41:8'h5a]}) begin
            s.val = 6'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7a]}) begin
            s.val = 6'(c - 8'h61 + 8'd26);
        end else if (c inside {[8'h30:8'h39]}) begin
            s.val = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2b) begin
            s.val = 6'd62;
        end else if (c == 8'h2f) begin
            s.val = 6'd63;
        end else begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/base64_stream_decoder.sv =====
// Top level of the Base64 stream decoder: decode core plus result queue.
// Depends on b64d_pkg, b64d_core, b64d_queue and base64_stream_decoder_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one Base64 character per
//   transaction with a flag marking the last character of a message.
//   Output channel (o_out_valid / i_out_stall) carries one result per
//   transaction: a decoded byte, or a single error result for a malformed
//   message, tagged with last-of-run and message-done flags.
//   Path: an accepted character is held in the input register, and the
//   results it yields are written into the result queue when it is consumed
//   and are visible on the output from then on. A quartet's three bytes leave in order.
//   Throughput: one character per cycle, sustained while the queue has room.
//   The output port drains one result per cycle unless stalled, from an 8-entry
//   queue; four characters yield at most three bytes, so the queue absorbs the bursts.
//   Stall: when the receiver stalls, the queue fills; once fewer than three
//   free entries remain, the held character waits in the input register and
//   o_in_stall rises. Nothing is dropped.
//   Reset (synchronous, active low) empties the queue and clears the quartet
//   and error-drop state.
`timescale 1ns / 1ps
`default_nettype none
`include "base64_stream_decoder_macros.svh"

module base64_stream_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // character input
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_end_of_message,
    // result output
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_out_kind,
    output logic            o_last_of_run,
    output logic            o_message_done
);
    import b64d_pkg::*;

    t_push   push;
    t_result head;
    logic    room;

    // Hold the character, decode it against the quartet state, push results.
    b64d_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_char_code      (i_char_code),
        .i_end_of_message (i_end_of_message),
        .i_room           (room),
        .o_push           (push)
    );

    // Buffer results and advance one per output transaction.
    b64d_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_head      (head)
    );

    assign o_out_byte     = head.out_byte;
    assign o_out_kind     = head.out_kind;
    assign o_last_of_run  = head.last_of_run;
    assign o_message_done = head.message_done;

    // Results are only pushed when the queue has space for a full quartet.
    `B64D_ASSERT_NOW(a_push_room, i_clk, i_rst_n, push.count != 2'd0, room, "push without room")

    // The input side stalls only because the queue is short of space.
    `B64D_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, !room, "stall with room")

    // An error is a lone result that ends both the run and the message.
    `B64D_ASSERT_NOW(a_err_alone, i_clk, i_rst_n, push.count != 2'd0 && push.res[0].out_kind, push.count == 2'd1 && push.res[0].last_of_run && push.res[0].message_done, "malformed error push")

    // A full quartet marks only its third byte as the end of the run.
    `B64D_ASSERT_NOW(a_quartet_last, i_clk, i_rst_n, push.count == 2'd3, push.res[2].last_of_run && !push.res[1].last_of_run && !push.res[0].last_of_run, "bad last flags")

endmodule

`default_nettype wire

// ===== hw/rtl/b64d_core.sv =====
// Input register, quartet state and result generation of the Base64 decoder.
// Depends on b64d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64d_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic [7:0]   i_char_code,
    input  wire logic         i_end_of_message,
    input  wire logic         i_room,
    output b64d_pkg::t_push   o_push
);
    import b64d_pkg::*;

    logic        r_vld, n_vld;
    logic [7:0]  r_char;
    logic        r_eom;
    logic [17:0] r_accum, n_accum;
    logic [1:0]  r_pos, n_pos;
    logic        r_third_pad, n_third_pad;
    logic        r_drop, n_drop;

    logic        load, consume, is_pad, err;
    t_sym        sym;
    logic [23:0] bits;
    t_push       push;

    assign consume    = r_vld && i_room;
    assign o_in_stall = r_vld && !i_room;
    assign load       = i_in_valid && !o_in_stall;

    assign n_vld = load || (r_vld && !consume);

    assign sym    = symbol_of(r_char);
    assign is_pad = (r_char == PAD_CHAR);
    assign bits   = {r_accum, (is_pad ? 6'd0 : sym.val)};

    always_comb begin
        n_accum     = r_accum;
        n_pos       = r_pos;
        n_third_pad = r_third_pad;
        n_drop      = r_drop;
        err         = 1'b0;
        push        = '0;
        if (consume) begin
            if (r_drop) begin
                // drop until the message ends
                if (r_eom) begin
                    n_drop      = 1'b0;
                    n_accum     = '0;
                    n_pos       = '0;
                    n_third_pad = 1'b0;
                end
            end else begin
                if (!is_pad && !sym.ok) begin
                    err = 1'b1;
                end else if (r_pos != 2'd3) begin
                    if (r_eom || (is_pad && r_pos != 2'd2) || (!is_pad && r_third_pad)) begin
                        err = 1'b1;
                    end else begin
                        n_accum     = {r_accum[11:0], (is_pad ? 6'd0 : sym.val)};
                        n_pos       = r_pos + 2'd1;
                        n_third_pad = r_third_pad || is_pad;
                    end
                end else if ((r_third_pad && !(is_pad && r_eom)) || (is_pad && !r_eom)) begin
                    err = 1'b1;
                end else begin
                    n_accum     = '0;
                    n_pos       = '0;
                    n_third_pad = 1'b0;
                    push.res[0] = '{bits[23:16], KIND_BYTE, 1'b0, 1'b0};
                    push.res[1] = '{bits[15:8],  KIND_BYTE, 1'b0, 1'b0};
                    push.res[2] = '{bits[7:0],   KIND_BYTE, 1'b0, 1'b0};
                    if (r_third_pad) begin
                        push.count              = 2'd1;
                        push.res[0].last_of_run  = 1'b1;
                        push.res[0].message_done = r_eom;
                    end else if (is_pad) begin
                        push.count              = 2'd2;
                        push.res[1].last_of_run  = 1'b1;
                        push.res[1].message_done = r_eom;
                    end else begin
                        push.count              = 2'd3;
                        push.res[2].last_of_run  = 1'b1;
                        push.res[2].message_done = r_eom;
                    end
                end
                if (err) begin
                    n_accum     = '0;
                    n_pos       = '0;
                    n_third_pad = 1'b0;
                    n_drop      = !r_eom;
                    push        = '0;
                    push.count  = 2'd1;
                    push.res[0] = '{8'd0, KIND_ERROR, 1'b1, 1'b1};
                end
            end
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= 1'b0;
            r_accum     <= '0;
            r_pos       <= '0;
            r_third_pad <= 1'b0;
            r_drop      <= 1'b0;
        end else begin
            r_vld       <= n_vld;
            r_accum     <= n_accum;
            r_pos       <= n_pos;
            r_third_pad <= n_third_pad;
            r_drop      <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= i_char_code;
            r_eom  <= i_end_of_message;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/b64d_queue.sv =====
// Result queue: takes up to three results per cycle, delivers one per cycle unless the output is stalled.
// Depends on b64d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64d_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire b64d_pkg::t_push i_push,
    output logic                o_room,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output b64d_pkg::t_result   o_head
);
    import b64d_pkg::*;

    t_result          r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0]   r_count, n_count;
    logic             pop;
    logic [QAW-1:0]   wa0, wa1, wa2;

    // room judged on the registered count alone; a pop only adds space
    assign o_room      = (r_count <= QCW'(QDEPTH - MAX_PUSH));
    assign o_out_valid = (r_count != '0);
    assign o_head      = r_mem[r_rd_ptr];
    assign pop         = o_out_valid && !i_out_stall;

    assign wa0 = r_wr_ptr;
    assign wa1 = r_wr_ptr + QAW'(1);
    assign wa2 = r_wr_ptr + QAW'(2);

    assign n_wr_ptr = r_wr_ptr + QAW'(i_push.count);
    assign n_rd_ptr = r_rd_ptr + QAW'(pop);
    assign n_count  = r_count + QCW'(i_push.count) - QCW'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count >= 2'd1) begin
            r_mem[wa0] <= i_push.res[0];
        end
        if (i_push.count >= 2'd2) begin
            r_mem[wa1] <= i_push.res[1];
        end
        if (i_push.count >= 2'd3) begin
            r_mem[wa2] <= i_push.res[2];
        end
    end

endmodule

`default_nettype wire
